// ===== rtl/bsr_pkg.sv =====
`default_nettype none

package bsr_pkg;

  localparam int COORD_BITS = 12;
  localparam int CANVAS_BITS = 13;
  localparam int SIZE_BITS = 3;
  localparam int COLOR_BITS = 32;
  localparam int ADDR_BITS = 24;
  localparam int CFG_INDEX_BITS = 4;
  localparam int MAX_STROKE_DEF = 7;

  localparam logic [CANVAS_BITS-1:0] CANVAS_LIMIT = CANVAS_BITS'(1 << COORD_BITS);
  localparam logic [CANVAS_BITS-1:0] CANVAS_RESET = CANVAS_BITS'(256);

  localparam logic [CFG_INDEX_BITS-1:0] REG_CANVAS_WIDTH = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_CANVAS_HEIGHT = CFG_INDEX_BITS'(1);

  typedef struct packed {
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    logic [SIZE_BITS-1:0]  stroke_size;
    logic                  rounded;
    logic [COLOR_BITS-1:0] color;
  } stamp_t;

  typedef struct packed {
    logic                   write_valid;
    logic [COORD_BITS-1:0]  pixel_x;
    logic [COORD_BITS-1:0]  pixel_y;
    logic [ADDR_BITS-1:0]   pixel_address;
    logic [COLOR_BITS-1:0]  pixel_color;
    logic [CANVAS_BITS-1:0] dirty_min_x;
    logic [CANVAS_BITS-1:0] dirty_min_y;
    logic [CANVAS_BITS-1:0] dirty_max_x;
    logic [CANVAS_BITS-1:0] dirty_max_y;
    logic                   last;
  } result_t;

  typedef struct packed {
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CANVAS_BITS-1:0]    wdata;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic row;
    logic step;
    logic close;
  } ctrl_cmd_t;

  typedef struct packed {
    logic keep;
    logic out_free;
    logic dx_end;
    logic dy_end;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/bsr_chan.sv =====
`default_nettype none

interface bsr_chan #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/brush_stamp_rasterizer.sv =====
`default_nettype none

// Brush stamp rasterizer: each stamp item (centre, stroke size, round or square
// shape, colour) yields one write item per pixel kept on the canvas, in rows top
// to bottom and left to right, then one closing item with last set that carries
// the dirty rectangle (min = canvas size and max = 0 when nothing was written).
// The scan sequencer tests one pixel per cycle while the result side does not
// stall, and passes through a row state before each row to form the row base
// address with the row-times-width multiplier. Canvas registers above 4096 act
// as 4096; configuration writes are always accepted and must only happen while
// no stamp is in flight.
module brush_stamp_rasterizer
  import bsr_pkg::*;
#(
  parameter int MAX_STROKE = MAX_STROKE_DEF
) (
  input logic    clk,
  input logic    rst,
  bsr_chan.sink   stamp,
  bsr_chan.source result,
  bsr_chan.sink   cfg
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       res_valid;
  result_t    res_data;

  assign cfg.ready = 1'b1;
  assign result.valid = res_valid;
  assign result.data = res_data;

  bsr_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .stamp_valid (stamp.valid),
    .stamp_ready (stamp.ready),
    .status      (status),
    .cmd         (cmd)
  );

  bsr_datapath #(
    .MAX_STROKE (MAX_STROKE)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .stamp_data (stamp.data),
    .cfg_write  (cfg.valid),
    .cfg_data   (cfg.data),
    .cmd        (cmd),
    .status     (status),
    .res_valid  (res_valid),
    .res_data   (res_data),
    .res_ready  (result.ready)
  );

endmodule

`default_nettype wire

// ===== rtl/bsr_ctrl.sv =====
`default_nettype none

module bsr_ctrl
  import bsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       stamp_valid,
  output logic       stamp_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ROW   = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_CLOSE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    stamp_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        stamp_ready = 1'b1;
        if (stamp_valid) begin
          cmd.load = 1'b1;
          state_next = ST_ROW;
        end
      end
      ST_ROW: begin
        cmd.row = 1'b1;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (!status.keep || status.out_free) begin
          cmd.step = 1'b1;
          if (status.dx_end) begin
            state_next = status.dy_end ? ST_CLOSE : ST_ROW;
          end
        end
      end
      ST_CLOSE: begin
        if (status.out_free) begin
          cmd.close = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_then_row: assert property (@(posedge clk) disable iff (rst)
    stamp_valid && stamp_ready |=> cmd.row)
    else $error("stamp item not followed by row setup");

  a_close_then_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.close |=> stamp_ready && !cmd.step && !cmd.row)
    else $error("closing item not followed by idle");
`endif

endmodule

`default_nettype wire

// ===== rtl/bsr_datapath.sv =====
`default_nettype none

module bsr_datapath
  import bsr_pkg::*;
#(
  parameter int MAX_STROKE = MAX_STROKE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  stamp_t     stamp_data,
  input  logic       cfg_write,
  input  cfg_t       cfg_data,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status,
  output logic       res_valid,
  output result_t    res_data,
  input  logic       res_ready
);

  localparam int RAD_MAX = MAX_STROKE / 2;
  localparam int RB = (RAD_MAX > 0) ? $clog2(RAD_MAX + 1) : 1;
  localparam int OB = RB + 1;
  localparam int SQB = 2 * OB + 1;
  localparam int PB = COORD_BITS + 2;
  localparam logic [SIZE_BITS-1:0] SIZE_CAP = SIZE_BITS'(MAX_STROKE);

  logic [CANVAS_BITS-1:0] canvas_width;
  logic [CANVAS_BITS-1:0] canvas_height;
  logic [CANVAS_BITS-1:0] w_eff;
  logic [CANVAS_BITS-1:0] h_eff;

  logic [COORD_BITS-1:0]  cx;
  logic [RB-1:0]          radius;
  logic                   rnd;
  logic [COLOR_BITS-1:0]  color;
  logic signed [OB-1:0]   dx;
  logic signed [OB-1:0]   dy;
  logic signed [PB-1:0]   px;
  logic signed [PB-1:0]   py;
  logic [ADDR_BITS-1:0]   row_base;
  logic                   row_ok;
  logic [CANVAS_BITS-1:0] mnx;
  logic [CANVAS_BITS-1:0] mny;
  logic [CANVAS_BITS-1:0] mxx;
  logic [CANVAS_BITS-1:0] mxy;

  logic [SIZE_BITS-1:0]   size_sat;
  logic [RB-1:0]          r_in;
  logic signed [OB-1:0]   r_in_s;
  logic signed [OB-1:0]   r_s;
  logic signed [SQB-1:0]  dxe;
  logic signed [SQB-1:0]  dye;
  logic signed [SQB-1:0]  re;
  logic                   in_circle;
  logic                   col_ok;
  logic                   keep;
  logic                   out_free;
  logic [CANVAS_BITS-1:0] px_u;
  logic [CANVAS_BITS-1:0] py_u;
  logic [CANVAS_BITS-1:0] px_u1;
  logic [CANVAS_BITS-1:0] py_u1;

  assign w_eff = (canvas_width > CANVAS_LIMIT) ? CANVAS_LIMIT : canvas_width;
  assign h_eff = (canvas_height > CANVAS_LIMIT) ? CANVAS_LIMIT : canvas_height;

  assign size_sat = (stamp_data.stroke_size > SIZE_CAP) ? SIZE_CAP : stamp_data.stroke_size;
  assign r_in = RB'(size_sat >> 1);
  assign r_in_s = signed'({1'b0, r_in});
  assign r_s = signed'({1'b0, radius});

  assign dxe = SQB'(dx);
  assign dye = SQB'(dy);
  assign re = SQB'(r_s);
  assign in_circle = (dxe * dxe + dye * dye) <= (re * re);

  assign px_u = px[CANVAS_BITS-1:0];
  assign py_u = py[CANVAS_BITS-1:0];
  assign px_u1 = px_u + CANVAS_BITS'(1);
  assign py_u1 = py_u + CANVAS_BITS'(1);

  assign col_ok = !px[PB-1] && (px[PB-2:0] < (PB-1)'(w_eff));
  assign keep = row_ok && col_ok && (!rnd || in_circle);
  assign out_free = !res_valid || res_ready;

  assign status.keep = keep;
  assign status.out_free = out_free;
  assign status.dx_end = (dx == r_s);
  assign status.dy_end = (dy == r_s);

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width <= CANVAS_RESET;
      canvas_height <= CANVAS_RESET;
    end else if (cfg_write) begin
      if (cfg_data.index == REG_CANVAS_WIDTH) begin
        canvas_width <= cfg_data.wdata;
      end else if (cfg_data.index == REG_CANVAS_HEIGHT) begin
        canvas_height <= cfg_data.wdata;
      end
    end
  end

  // scan position and dirty rectangle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx <= stamp_data.center_x;
      radius <= r_in;
      rnd <= stamp_data.rounded;
      color <= stamp_data.color;
      dy <= -r_in_s;
      py <= signed'(PB'(stamp_data.center_y)) - PB'(r_in_s);
      mnx <= w_eff;
      mny <= h_eff;
      mxx <= '0;
      mxy <= '0;
    end
    if (cmd.row) begin
      row_base <= ADDR_BITS'(py[COORD_BITS-1:0] * w_eff);
      row_ok <= !py[PB-1] && (py[PB-2:0] < (PB-1)'(h_eff));
      dx <= -r_s;
      px <= signed'(PB'(cx)) - PB'(r_s);
    end
    if (cmd.step) begin
      if (status.dx_end) begin
        dy <= dy + OB'(1);
        py <= py + PB'(1);
      end else begin
        dx <= dx + OB'(1);
        px <= px + PB'(1);
      end
      if (keep) begin
        if (px_u < mnx) begin
          mnx <= px_u;
        end
        if (py_u < mny) begin
          mny <= py_u;
        end
        if (px_u1 > mxx) begin
          mxx <= px_u1;
        end
        if (py_u1 > mxy) begin
          mxy <= py_u1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((cmd.step && keep) || cmd.close) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && keep) begin
      res_data.write_valid <= 1'b1;
      res_data.pixel_x <= px[COORD_BITS-1:0];
      res_data.pixel_y <= py[COORD_BITS-1:0];
      res_data.pixel_address <= row_base + ADDR_BITS'(px[COORD_BITS-1:0]);
      res_data.pixel_color <= color;
      res_data.dirty_min_x <= '0;
      res_data.dirty_min_y <= '0;
      res_data.dirty_max_x <= '0;
      res_data.dirty_max_y <= '0;
      res_data.last <= 1'b0;
    end else if (cmd.close) begin
      res_data.write_valid <= 1'b0;
      res_data.pixel_x <= '0;
      res_data.pixel_y <= '0;
      res_data.pixel_address <= '0;
      res_data.pixel_color <= '0;
      res_data.dirty_min_x <= mnx;
      res_data.dirty_min_y <= mny;
      res_data.dirty_max_x <= mxx;
      res_data.dirty_max_y <= mxy;
      res_data.last <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_write_on_canvas: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.write_valid |->
      (CANVAS_BITS'(res_data.pixel_x) < w_eff) && (CANVAS_BITS'(res_data.pixel_y) < h_eff))
    else $error("pixel write item outside the canvas");

  a_write_address: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.write_valid |->
      res_data.pixel_address ==
        ADDR_BITS'(res_data.pixel_y * w_eff) + ADDR_BITS'(res_data.pixel_x))
    else $error("pixel address does not match row and column");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_brush_stamp_rasterizer.sv =====
`default_nettype none

import bsr_pkg::*;

class pixel_ledger;
  logic [CANVAS_BITS-1:0] width_reg;
  logic [CANVAS_BITS-1:0] height_reg;
  result_t expected_writes[$];
  int unsigned errors;

  function new();
    width_reg = CANVAS_RESET;
    height_reg = CANVAS_RESET;
    errors = 0;
  endfunction

  function void set_register(cfg_t c);
    case (c.index)
      REG_CANVAS_WIDTH: width_reg = c.wdata;
      REG_CANVAS_HEIGHT: height_reg = c.wdata;
      default: ;
    endcase
  endfunction

  function int span(logic [CANVAS_BITS-1:0] v);
    return (v > CANVAS_LIMIT) ? int'(CANVAS_LIMIT) : int'(v);
  endfunction

  // one write per kept pixel in scan order, then the dirty rectangle
  function void add_stamp(stamp_t s);
    int w;
    int h;
    int sz;
    int r;
    int px;
    int py;
    int mnx;
    int mny;
    int mxx;
    int mxy;
    result_t e;
    w = span(width_reg);
    h = span(height_reg);
    sz = int'(s.stroke_size);
    if (sz > MAX_STROKE_DEF) sz = MAX_STROKE_DEF;
    r = sz / 2;
    mnx = w;
    mny = h;
    mxx = 0;
    mxy = 0;
    for (int dy = -r; dy <= r; dy++) begin
      for (int dx = -r; dx <= r; dx++) begin
        px = int'(s.center_x) + dx;
        py = int'(s.center_y) + dy;
        if (px < 0 || py < 0 || px >= w || py >= h) continue;
        if (s.rounded && (dx * dx + dy * dy > r * r)) continue;
        e = '0;
        e.write_valid = 1'b1;
        e.pixel_x = px[COORD_BITS-1:0];
        e.pixel_y = py[COORD_BITS-1:0];
        e.pixel_address = ADDR_BITS'(py * w + px);
        e.pixel_color = s.color;
        expected_writes.push_back(e);
        if (px < mnx) mnx = px;
        if (py < mny) mny = py;
        if (px + 1 > mxx) mxx = px + 1;
        if (py + 1 > mxy) mxy = py + 1;
      end
    end
    e = '0;
    e.dirty_min_x = CANVAS_BITS'(mnx);
    e.dirty_min_y = CANVAS_BITS'(mny);
    e.dirty_max_x = CANVAS_BITS'(mxx);
    e.dirty_max_y = CANVAS_BITS'(mxy);
    e.last = 1'b1;
    expected_writes.push_back(e);
  endfunction

  function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
    if (seen !== want) begin
      errors++;
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, seen);
    end
  endfunction

  function void check_write(result_t got);
    result_t exp;
    if (expected_writes.size() == 0) begin
      errors++;
      $display("%0t unexpected item: expected none actual %h", $time, got);
      return;
    end
    exp = expected_writes.pop_front();
    compare_field("write_valid", exp.write_valid, got.write_valid);
    compare_field("pixel_x", exp.pixel_x, got.pixel_x);
    compare_field("pixel_y", exp.pixel_y, got.pixel_y);
    compare_field("pixel_address", exp.pixel_address, got.pixel_address);
    compare_field("pixel_color", exp.pixel_color, got.pixel_color);
    compare_field("dirty_min_x", exp.dirty_min_x, got.dirty_min_x);
    compare_field("dirty_min_y", exp.dirty_min_y, got.dirty_min_y);
    compare_field("dirty_max_x", exp.dirty_max_x, got.dirty_max_x);
    compare_field("dirty_max_y", exp.dirty_max_y, got.dirty_max_y);
    compare_field("last", exp.last, got.last);
  endfunction
endclass

module tb_brush_stamp_rasterizer;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_PER_PHASE = 41;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = CFG_INDEX_BITS'(15);

  logic clk = 1'b0;
  logic rst = 1'b1;
  int src_idle_pct = 20;
  int recv_idle_pct = 50;
  int cycle_count = 0;
  pixel_ledger ledger = new();

  bsr_chan #(.T(stamp_t)) stamp_if ();
  bsr_chan #(.T(result_t)) result_if ();
  bsr_chan #(.T(cfg_t)) cfg_if ();

  brush_stamp_rasterizer dut (
    .clk(clk),
    .rst(rst),
    .stamp(stamp_if),
    .result(result_if),
    .cfg(cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL brush_stamp_rasterizer");
      $finish;
    end
  end

  initial begin
    result_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      result_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && result_if.valid === 1'b1 && result_if.ready === 1'b1)
        ledger.check_write(result_if.data);
    end
  end

  task automatic send_stamp(input stamp_t s);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      stamp_if.valid <= 1'b0;
      @(negedge clk);
    end
    stamp_if.valid <= 1'b1;
    stamp_if.data <= s;
    @(posedge clk);
    while (stamp_if.ready !== 1'b1) @(posedge clk);
    ledger.add_stamp(s);
    @(negedge clk);
  endtask

  task automatic send_fields(input int x, input int y, input int sz, input bit rnd,
                             input logic [COLOR_BITS-1:0] c);
    stamp_t s;
    s.center_x = COORD_BITS'(x);
    s.center_y = COORD_BITS'(y);
    s.stroke_size = SIZE_BITS'(sz);
    s.rounded = rnd;
    s.color = c;
    send_stamp(s);
  endtask

  // hold the stamp side off until every pending item has come back
  task automatic drain();
    stamp_if.valid <= 1'b0;
    @(negedge clk);
    while (ledger.expected_writes.size() != 0) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [CANVAS_BITS-1:0] val);
    cfg_t c;
    c.index = idx;
    c.wdata = val;
    cfg_if.valid <= 1'b1;
    cfg_if.data <= c;
    @(posedge clk);
    while (cfg_if.ready !== 1'b1) @(posedge clk);
    ledger.set_register(c);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_canvas(input logic [CANVAS_BITS-1:0] w, input logic [CANVAS_BITS-1:0] h);
    drain();
    repeat (4) @(negedge clk);
    write_register(REG_CANVAS_WIDTH, w);
    write_register(REG_CANVAS_HEIGHT, h);
  endtask

  function automatic int pick_coord(int lim);
    int l;
    l = (lim < 1) ? 1 : lim;
    case ($urandom_range(0, 3))
      0: return int'($urandom_range(0, 4095));
      1: return int'($urandom_range(0, 3));
      2: return (l + int'($urandom_range(0, 7)) - 4) & 12'hFFF;
      default: return int'($urandom_range(0, l - 1)) & 12'hFFF;
    endcase
  endfunction

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 29) == 0) drain();
      send_fields(pick_coord(ledger.span(ledger.width_reg)),
                  pick_coord(ledger.span(ledger.height_reg)),
                  $urandom_range(0, 7), 1'($urandom_range(0, 1)), $urandom);
    end
  endtask

  initial begin
    stamp_if.valid <= 1'b0;
    stamp_if.data <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset canvas 256 x 256: every size and shape, then corners and far off canvas
    for (int sz = 0; sz < 8; sz++) begin
      send_fields(100, 100, sz, 1'b0, 32'h1234_5678 + sz);
      send_fields(100, 100, sz, 1'b1, 32'h8765_4321 - sz);
    end
    send_fields(0, 0, 7, 1'b1, 32'h0000_0000);
    send_fields(255, 255, 7, 1'b0, 32'hFFFF_FFFF);
    send_fields(4095, 4095, 7, 1'b0, 32'hFFFF_FFFF);
    send_fields(0, 255, 6, 1'b1, 32'hA5A5_A5A5);
    send_fields(255, 0, 5, 1'b0, 32'h5A5A_5A5A);
    run_random(RANDOM_PER_PHASE);

    set_canvas(13'd4096, 13'd4096);
    send_fields(4095, 4095, 7, 1'b1, 32'hFFFF_FFFF);
    send_fields(0, 4095, 7, 1'b0, 32'h0);
    run_random(RANDOM_PER_PHASE);

    src_idle_pct = 50;
    recv_idle_pct = 20;
    set_canvas(13'h1FFF, 13'd0);
    write_register(REG_UNUSED, 13'd5);
    run_random(RANDOM_PER_PHASE);

    set_canvas(13'd1, 13'd1);
    send_fields(0, 0, 7, 1'b1, 32'hCAFE_0001);
    run_random(RANDOM_PER_PHASE);

    src_idle_pct = 0;
    recv_idle_pct = 0;
    set_canvas(13'd0, 13'h1FFF);
    run_random(RANDOM_PER_PHASE);

    set_canvas(13'd4097, 13'($urandom_range(1, 4096)));
    run_random(RANDOM_PER_PHASE / 2);
    set_canvas(13'($urandom_range(1, 64)), 13'($urandom_range(1, 64)));
    run_random(RANDOM_PER_PHASE / 2);

    drain();
    repeat (60) @(posedge clk);
    if (ledger.errors == 0 && ledger.expected_writes.size() == 0) begin
      $display("PASS brush_stamp_rasterizer");
    end else begin
      $display("FAIL brush_stamp_rasterizer");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ===== files.f =====
rtl/bsr_pkg.sv
rtl/bsr_chan.sv
rtl/bsr_ctrl.sv
rtl/bsr_datapath.sv
rtl/brush_stamp_rasterizer.sv
tb/sv/tb_brush_stamp_rasterizer.sv
